[rtl/core/vsa_pkg.sv]
// Shared types, status codes and helpers for the variable size allocator.
package vsa_pkg;

   localparam int AW     = 32;
   localparam int IDXW   = 10;
   localparam int NEED_W = AW + 2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_NOFIT = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_BAD   = 2'd3;

   localparam logic CMD_ALLOC = 1'b0;

   typedef struct packed {
      logic            best_hit;
      logic [AW-1:0]   best_off;
      logic [AW-1:0]   best_len;
      logic [IDXW-1:0] best_idx;
      logic            prev_hit;
      logic [AW-1:0]   prev_off;
      logic [AW-1:0]   prev_len;
      logic [IDXW-1:0] prev_idx;
      logic            next_hit;
      logic [AW-1:0]   next_off;
      logic [AW-1:0]   next_len;
      logic [IDXW-1:0] next_idx;
      logic            slot_hit;
      logic [IDXW-1:0] slot_idx;
   } carry_type;

   typedef struct packed {
      logic [NEED_W-1:0] need;
      logic [AW-1:0]     key;
   } query_type;

   typedef struct packed {
      logic            init_en;
      logic [AW-1:0]   init_len;
      logic            a_en;
      logic [IDXW-1:0] a_idx;
      logic            a_valid;
      logic [AW-1:0]   a_off;
      logic [AW-1:0]   a_len;
      logic            b_en;
      logic [IDXW-1:0] b_idx;
   } wr_type;

   // Largest power of two not above x; one for zero.
   function automatic logic [AW-1:0] top_pow2(input logic [AW-1:0] x);
      logic [AW-1:0] s;
      s = x;
      for (int k = 1; k < AW; k = k * 2) begin
         s = s | (s >> k);
      end
      if (x == '0) begin
         return AW'(1);
      end
      return s ^ (s >> 1);
   endfunction

endpackage

[rtl/core/vsa_cell.sv]
// One free-table entry with its stage of the best-fit and neighbor search chain.
module vsa_cell import vsa_pkg::*; #(
   parameter int CELL_IDX = 0
) (
   input  logic      clock,
   input  logic      reset,
   input  carry_type left_carry,
   output carry_type right_carry,
   input  query_type query,
   input  wr_type    wr
);

   localparam logic [IDXW-1:0] MY_IDX = IDXW'(CELL_IDX);

   logic            valid_ff;
   logic [AW-1:0]   off_ff;
   logic [AW-1:0]   len_ff;
   carry_type       carry_ff;
   carry_type       carry_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= (CELL_IDX == 0);
         off_ff   <= '0;
         len_ff   <= (CELL_IDX == 0) ? {AW{1'b1}} : '0;
      end else if (wr.init_en) begin
         valid_ff <= (CELL_IDX == 0) && (wr.init_len != '0);
         off_ff   <= '0;
         len_ff   <= wr.init_len;
      end else begin
         if (wr.a_en && wr.a_idx == MY_IDX) begin
            valid_ff <= wr.a_valid;
            off_ff   <= wr.a_off;
            len_ff   <= wr.a_len;
         end
         if (wr.b_en && wr.b_idx == MY_IDX) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      carry_in = left_carry;
      if (valid_ff) begin
         if ({2'b00, len_ff} >= query.need &&
             (!left_carry.best_hit || len_ff < left_carry.best_len ||
              (len_ff == left_carry.best_len && off_ff < left_carry.best_off))) begin
            carry_in.best_hit = 1'b1;
            carry_in.best_off = off_ff;
            carry_in.best_len = len_ff;
            carry_in.best_idx = MY_IDX;
         end
         if (off_ff <= query.key) begin
            if (!left_carry.prev_hit || off_ff > left_carry.prev_off) begin
               carry_in.prev_hit = 1'b1;
               carry_in.prev_off = off_ff;
               carry_in.prev_len = len_ff;
               carry_in.prev_idx = MY_IDX;
            end
         end else if (!left_carry.next_hit || off_ff < left_carry.next_off) begin
            carry_in.next_hit = 1'b1;
            carry_in.next_off = off_ff;
            carry_in.next_len = len_ff;
            carry_in.next_idx = MY_IDX;
         end
      end else if (!left_carry.slot_hit) begin
         carry_in.slot_hit = 1'b1;
         carry_in.slot_idx = MY_IDX;
      end
   end

   always_ff @(posedge clock) begin
      carry_ff <= carry_in;
   end

   assign right_carry = carry_ff;

endmodule

[rtl/core/variable_size_allocator.sv]
// Best-fit free-list allocator: control sequencer over a chain of table cells.
// An accepted request passes S_CALC, the search wave in S_SCAN that walks the chain
// one cell per cycle, S_ADJ, S_SUM and S_DONE (an allocation with no hit leaves at
// S_ADJ); requests rejected up front (zero size, too large, free beyond capacity) leave
// at S_CALC. One request at a time; reset leaves capacity 2^32-1 as one free block.
module variable_size_allocator import vsa_pkg::*; #(
   parameter int MAX_FREE_BLOCKS = 64
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic          req_command,
   input  logic [31:0]   req_request_size,
   input  logic [4:0]    req_align_log2,
   input  logic [31:0]   req_free_offset,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [1:0]    rsp_status,
   output logic [31:0]   rsp_block_start,
   output logic [31:0]   rsp_block_length,
   output logic [31:0]   rsp_bytes_free,
   input  logic          csr_write_enable,
   input  logic [31:0]   csr_write_data
);

   localparam int CW = $clog2(MAX_FREE_BLOCKS + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_CALC = 3'd1;
   localparam logic [2:0] S_SCAN = 3'd2;
   localparam logic [2:0] S_ADJ  = 3'd3;
   localparam logic [2:0] S_SUM  = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;
   localparam logic [2:0] S_HOLD = 3'd6;

   logic [2:0]        state_ff, state_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [AW-1:0]     cap_ff, cap_in;
   logic [AW-1:0]     cap_top_ff, cap_top_in;
   logic [AW-1:0]     free_total_ff, free_total_in;
   logic [AW-1:0]     min_align_ff, min_align_in;

   logic              cmd_ff;
   logic [AW-1:0]     size_ff;
   logic [4:0]        lg_ff;
   logic [AW-1:0]     key_ff;
   logic [AW:0]       asz_ff, asz_in;
   logic [AW:0]       end_ff, end_in;
   logic [AW:0]       sum_ff, sum_in;
   logic [AW+1:0]     adj_ff, adj_in;
   query_type         query_ff, query_in;
   logic [1:0]        res_status_ff, res_status_in;
   logic [AW-1:0]     res_start_ff, res_start_in;
   logic [AW-1:0]     res_len_ff, res_len_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff;
   logic [AW-1:0]     rsp_start_ff, rsp_len_ff, rsp_free_ff;
   logic              rsp_load;

   logic [AW-1:0]     mask_c, align_c, reserve_c, rem_c, new_free_c;
   logic [AW:0]       asz_c;
   wr_type            wr;
   carry_type         chain [MAX_FREE_BLOCKS+1];
   carry_type         last;

   assign chain[0] = '0;
   assign last     = chain[MAX_FREE_BLOCKS];

   for (genvar g = 0; g < MAX_FREE_BLOCKS; g++) begin : g_cell
      vsa_cell #(.CELL_IDX(g)) u_cell (
         .clock       (clock),
         .reset       (reset),
         .left_carry  (chain[g]),
         .right_carry (chain[g+1]),
         .query       (query_ff),
         .wr          (wr)
      );
   end

   assign mask_c    = ~({AW{1'b1}} << lg_ff);
   assign align_c   = AW'(1) << lg_ff;
   assign asz_c     = ({1'b0, size_ff} + {1'b0, mask_c}) & ~{1'b0, mask_c};
   assign reserve_c = (align_c > min_align_ff) ? align_c - min_align_ff : '0;
   assign rem_c     = last.best_len - adj_ff[AW-1:0];
   assign new_free_c = free_total_ff + size_ff;
   assign rsp_load  = (state_ff == S_HOLD) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      cap_in        = cap_ff;
      cap_top_in    = cap_top_ff;
      free_total_in = free_total_ff;
      min_align_in  = min_align_ff;
      asz_in        = asz_ff;
      end_in        = end_ff;
      sum_in        = sum_ff;
      adj_in        = adj_ff;
      query_in      = query_ff;
      res_status_in = res_status_ff;
      res_start_in  = res_start_ff;
      res_len_in    = res_len_ff;
      wr            = '0;
      wr.init_en    = csr_write_enable;
      wr.init_len   = csr_write_data;

      if (csr_write_enable) begin
         cap_in        = csr_write_data;
         cap_top_in    = top_pow2(csr_write_data);
         free_total_in = csr_write_data;
         min_align_in  = top_pow2(csr_write_data);
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            res_status_in = ST_OK;
            res_start_in  = '0;
            res_len_in    = '0;
            asz_in        = asz_c;
            end_in        = {1'b0, key_ff} + {1'b0, size_ff};
            query_in.key  = key_ff;
            query_in.need = {1'b0, asz_c} + {2'b00, reserve_c};
            cnt_in        = '0;
            if (cmd_ff == CMD_ALLOC) begin
               if (size_ff == '0) begin
                  res_status_in = ST_BAD;
                  state_in      = S_HOLD;
               end else if ({1'b0, free_total_ff} < asz_c) begin
                  res_status_in = ST_NOFIT;
                  state_in      = S_HOLD;
               end else begin
                  state_in = S_SCAN;
               end
            end else if (size_ff == '0 ||
                         ({1'b0, key_ff} + {1'b0, size_ff}) > {1'b0, cap_ff}) begin
               res_status_in = ST_BAD;
               state_in      = S_HOLD;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(MAX_FREE_BLOCKS - 1)) begin
               state_in = S_ADJ;
            end
         end
         S_ADJ: begin
            if (cmd_ff == CMD_ALLOC) begin
               sum_in = ({1'b0, last.best_off} + {1'b0, mask_c}) & ~{1'b0, mask_c};
               if (!last.best_hit) begin
                  res_status_in = ST_NOFIT;
                  state_in      = S_HOLD;
               end else begin
                  state_in = S_SUM;
               end
            end else begin
               sum_in   = {1'b0, last.prev_off} + {1'b0, last.prev_len};
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            adj_in   = {1'b0, asz_ff} + {1'b0, sum_ff - {1'b0, last.best_off}};
            state_in = S_DONE;
         end
         S_DONE: begin
            state_in = S_HOLD;
            if (cmd_ff == CMD_ALLOC) begin
               if (adj_ff > {2'b00, last.best_len}) begin
                  res_status_in = ST_NOFIT;
               end else begin
                  wr.a_en       = 1'b1;
                  wr.a_idx      = last.best_idx;
                  wr.a_valid    = (rem_c != '0);
                  wr.a_off      = last.best_off + adj_ff[AW-1:0];
                  wr.a_len      = rem_c;
                  free_total_in = free_total_ff - adj_ff[AW-1:0];
                  if ((asz_ff & {1'b0, min_align_ff - AW'(1)}) != '0) begin
                     if ((asz_ff & (asz_ff - (AW+1)'(1))) == '0) begin
                        min_align_in = asz_ff[AW-1:0];
                     end else if (align_c < min_align_ff) begin
                        min_align_in = align_c;
                     end
                  end
                  res_start_in = last.best_off;
                  res_len_in   = adj_ff[AW-1:0];
               end
            end else begin
               priority if ((last.next_hit && end_ff > {1'b0, last.next_off}) ||
                            (last.prev_hit && {1'b0, key_ff} < sum_ff)) begin
                  res_status_in = ST_BAD;
               end else if (last.prev_hit && {1'b0, key_ff} == sum_ff) begin
                  // Merge into the block below, and absorb the block above if it touches.
                  wr.a_en    = 1'b1;
                  wr.a_idx   = last.prev_idx;
                  wr.a_valid = 1'b1;
                  wr.a_off   = last.prev_off;
                  if (last.next_hit && end_ff == {1'b0, last.next_off}) begin
                     wr.a_len = last.prev_len + size_ff + last.next_len;
                     wr.b_en  = 1'b1;
                     wr.b_idx = last.next_idx;
                  end else begin
                     wr.a_len = last.prev_len + size_ff;
                  end
               end else if (last.next_hit && end_ff == {1'b0, last.next_off}) begin
                  wr.a_en    = 1'b1;
                  wr.a_idx   = last.next_idx;
                  wr.a_valid = 1'b1;
                  wr.a_off   = key_ff;
                  wr.a_len   = last.next_len + size_ff;
               end else if (last.slot_hit) begin
                  wr.a_en    = 1'b1;
                  wr.a_idx   = last.slot_idx;
                  wr.a_valid = 1'b1;
                  wr.a_off   = key_ff;
                  wr.a_len   = size_ff;
               end else begin
                  res_status_in = ST_FULL;
               end
               if (res_status_in == ST_OK) begin
                  free_total_in = new_free_c;
                  if (new_free_c == cap_ff) begin
                     min_align_in = cap_top_ff;
                  end
               end
            end
         end
         S_HOLD: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_ff        <= '0;
         cap_ff        <= {AW{1'b1}};
         cap_top_ff    <= AW'(1) << (AW - 1);
         free_total_ff <= {AW{1'b1}};
         min_align_ff  <= AW'(1) << (AW - 1);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         cap_ff        <= cap_in;
         cap_top_ff    <= cap_top_in;
         free_total_ff <= free_total_in;
         min_align_ff  <= min_align_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         cmd_ff  <= req_command;
         size_ff <= req_request_size;
         lg_ff   <= req_align_log2;
         key_ff  <= req_free_offset;
      end
      asz_ff        <= asz_in;
      end_ff        <= end_in;
      sum_ff        <= sum_in;
      adj_ff        <= adj_in;
      query_ff      <= query_in;
      res_status_ff <= res_status_in;
      res_start_ff  <= res_start_in;
      res_len_ff    <= res_len_in;
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_start_ff  <= res_start_ff;
         rsp_len_ff    <= res_len_ff;
         rsp_free_ff   <= free_total_ff;
      end
   end

   assign req_ready        = (state_ff == S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_block_start  = rsp_start_ff;
   assign rsp_block_length = rsp_len_ff;
   assign rsp_bytes_free   = rsp_free_ff;

   a_free_le_cap: assert property (@(posedge clock) disable iff (reset)
      free_total_ff <= cap_ff)
      else $error("free byte count exceeds capacity");

   a_min_align_pow2: assert property (@(posedge clock) disable iff (reset)
      $onehot(min_align_ff))
      else $error("minimum alignment is not a power of two");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == S_CALC)
      else $error("accepted request beat did not start processing");

   a_one_write: assert property (@(posedge clock) disable iff (reset)
      wr.a_en |-> state_ff == S_DONE)
      else $error("table written outside the decision cycle");

endmodule
